/* rtl/srd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srd_pkg
// Shared widths, phase codes, register indexes, error codes and limits for the scanline
// run-length sprite decoder.
// ----------------------------------------------------------------------------
package srd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PIX_W   = 16;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned ERR_W   = 2;
	localparam int unsigned SIZE_W  = 24;
	localparam int unsigned LINE_W  = 32;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_PIXELS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_SIZE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd3;

	// decoder phases
	localparam int unsigned PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_HDR   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_VALUE = 3'd1;
	localparam logic [PHASE_W-1:0] PH_COUNT = 3'd2;
	localparam logic [PHASE_W-1:0] PH_PAD   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_LINE_LEN = 2'd1;
	localparam logic [ERR_W-1:0] ERR_CAPACITY = 2'd2;

	localparam int unsigned MAX_LINE_WORDS = 1000;
	localparam int unsigned HDR_BYTES      = 4;

endpackage
`default_nettype wire

/* rtl/srd_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srd_in_if
// Byte stream channel into the decoder: valid, ready and one encoded byte.
// ----------------------------------------------------------------------------
interface srd_in_if
	import srd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

/* rtl/srd_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srd_out_if
// Run channel out of the decoder: valid, ready, run value, run count,
// end-of-image flag and error code.
// ----------------------------------------------------------------------------
interface srd_out_if
	import srd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   run_value;
	logic [COUNT_W-1:0] run_count;
	logic               image_done;
	logic [ERR_W-1:0]   error_code;

	modport source (output valid, output run_value, output run_count,
		output image_done, output error_code, input ready);
	modport sink   (input valid, input run_value, input run_count,
		input image_done, input error_code, output ready);
endinterface
`default_nettype wire

/* rtl/scanline_rle_sprite_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scanline_rle_sprite_decoder
// Parses scanline headers, pixels and escape counts from an encoded byte
// stream and issues one clipped run per pixel value.
//
//   channel  dir  handshake      payload
//   stream   in   valid/ready    data_byte
//   runs     out  valid/ready    run_value, run_count, image_done, error_code
//   cfg      in   cfg_wr_en      cfg_index, cfg_data
//
// One byte per cycle: each byte updates the decoder state in the cycle it is
// taken and any run it causes lands in the output register on that edge.
// The output register decouples the sides: a byte is taken whenever the
// register is empty or is being emptied in the same cycle.
// Reset clears all control state; writing data_size_bytes restarts an image.
// ----------------------------------------------------------------------------
module scanline_rle_sprite_decoder
	import srd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	srd_in_if.sink                    stream,
	srd_out_if.source                 runs
);

	// configuration
	logic                  wide_q;
	logic [PIX_W-1:0]      transp_q;

	// decoder state
	logic [PHASE_W-1:0]    phase_q;
	logic [1:0]            hidx_q;
	logic [LINE_W-1:0]     line_q;
	logic [LINE_W-1:0]     data_q;
	logic [SIZE_W-1:0]     cap_q;
	logic [PIX_W-1:0]      held_q;
	logic [BYTE_W-1:0]     low_q;
	logic                  pad_q;
	logic [ERR_W-1:0]      err_q;

	// output register
	logic                  out_valid_q;
	logic [PIX_W-1:0]      out_value_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_done_q;
	logic [ERR_W-1:0]      out_err_q;

	// next state
	logic [PHASE_W-1:0]    n_phase;
	logic [1:0]            n_hidx;
	logic [LINE_W-1:0]     n_line;
	logic [LINE_W-1:0]     n_data;
	logic [SIZE_W-1:0]     n_cap;
	logic [PIX_W-1:0]      n_held;
	logic [BYTE_W-1:0]     n_low;
	logic                  n_pad;
	logic [ERR_W-1:0]      n_err;

	logic                  res_valid;
	logic [PIX_W-1:0]      res_value;
	logic [COUNT_W-1:0]    res_count;
	logic                  res_done;
	logic [ERR_W-1:0]      res_err;

	logic                  take;

	assign stream.ready = !out_valid_q || runs.ready;
	assign take         = stream.valid && stream.ready;

	always_comb begin
		logic              idle;
		logic              emit_go;
		logic [PIX_W-1:0]  emit_val;
		logic [COUNT_W-1:0] emit_cnt;
		logic              chk_after;
		logic              do_end;
		logic [LINE_W-1:0] hdr_word;
		logic [LINE_W-1:0] s_len;
		logic [LINE_W-1:0] s_rnd;
		logic [LINE_W-1:0] len;
		logic [PIX_W-1:0]  word;
		logic [PIX_W-1:0]  t_val;
		logic [PIX_W-1:0]  w_rnd;
		logic [SIZE_W-2:0] avail;
		logic [COUNT_W-1:0] n_run;

		n_phase = phase_q;
		n_hidx  = hidx_q;
		n_line  = line_q;
		n_data  = data_q;
		n_cap   = cap_q;
		n_held  = held_q;
		n_low   = low_q;
		n_pad   = pad_q;
		n_err   = err_q;

		res_valid = 1'b0;
		res_value = '0;
		res_count = '0;
		res_done  = 1'b0;
		res_err   = ERR_NONE;

		emit_go   = 1'b0;
		emit_val  = '0;
		emit_cnt  = '0;
		chk_after = 1'b0;
		do_end    = 1'b0;
		hdr_word  = '0;
		s_len     = '0;
		s_rnd     = '0;
		len       = '0;
		word      = '0;
		t_val     = '0;
		w_rnd     = '0;
		avail     = '0;
		n_run     = '0;

		idle = (err_q != ERR_NONE) || (phase_q == PH_DONE) ||
			((phase_q == PH_HDR) && (data_q == '0 || data_q[LINE_W-1]));

		if (!idle) begin
			unique case (phase_q)
				PH_HDR: begin
					hdr_word = (hidx_q == 2'd0) ? '0 : line_q;
					hdr_word[{hidx_q, 3'b000} +: BYTE_W] = stream.data_byte;
					n_line = hdr_word;
					if (hidx_q == 2'(HDR_BYTES - 1)) begin
						n_hidx = 2'd0;
						if (wide_q) begin
							// signed halving, rounded toward zero
							s_len = hdr_word - LINE_W'(HDR_BYTES);
							s_rnd = s_len + {{(LINE_W-1){1'b0}}, s_len[LINE_W-1]};
							len   = {s_rnd[LINE_W-1], s_rnd[LINE_W-1:1]};
							if (!len[LINE_W-1] && len > LINE_W'(MAX_LINE_WORDS)) begin
								n_err     = ERR_LINE_LEN;
								res_err   = ERR_LINE_LEN;
								res_valid = 1'b1;
							end else begin
								n_data = data_q - (LINE_W'(HDR_BYTES) +
									{len[LINE_W-2:0], 1'b0});
								n_pad  = len[0];
								n_line = len;
							end
						end else begin
							n_data = data_q - hdr_word;
							n_pad  = 1'b0;
							n_line = hdr_word - LINE_W'(HDR_BYTES);
						end
						if (n_err == ERR_NONE) begin
							if (n_line == '0 || n_line[LINE_W-1]) begin
								do_end = 1'b1;
							end else begin
								n_phase = PH_VALUE;
							end
						end
					end else begin
						n_hidx = hidx_q + 2'd1;
					end
				end
				PH_VALUE, PH_COUNT: begin
					if (wide_q && hidx_q == 2'd0) begin
						n_low  = stream.data_byte;
						n_hidx = 2'd1;
					end else begin
						n_hidx = 2'd0;
						word   = wide_q ? {stream.data_byte, low_q}
							: {{(PIX_W-BYTE_W){1'b0}}, stream.data_byte};
						n_line = line_q - LINE_W'(1);
						if (phase_q == PH_VALUE) begin
							t_val = wide_q ? transp_q
								: {{(PIX_W-BYTE_W){1'b0}}, transp_q[BYTE_W-1:0]};
							if (word == t_val) begin
								n_held  = word;
								n_phase = PH_COUNT;
							end else begin
								emit_go   = 1'b1;
								emit_val  = word;
								emit_cnt  = COUNT_W'(1);
								chk_after = 1'b1;
							end
						end else begin
							// wide count: signed word halved toward zero
							w_rnd = word + {{(PIX_W-1){1'b0}}, word[PIX_W-1]};
							n_phase   = PH_VALUE;
							emit_go   = 1'b1;
							emit_val  = held_q;
							emit_cnt  = wide_q ? {w_rnd[PIX_W-1], w_rnd[PIX_W-1:1]} : word;
							chk_after = 1'b1;
						end
					end
				end
				PH_PAD: begin
					if (hidx_q == 2'd0) begin
						n_hidx = 2'd1;
					end else begin
						n_data = data_q - LINE_W'(2);
						n_pad  = 1'b0;
						do_end = 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (emit_go) begin
				if (wide_q) begin
					avail = cap_q[SIZE_W-1:1];
					n_run = ({{(SIZE_W-1-COUNT_W){1'b0}}, emit_cnt} < avail)
						? emit_cnt : avail[COUNT_W-1:0];
					n_cap = cap_q - {{(SIZE_W-COUNT_W-1){1'b0}}, n_run, 1'b0};
					if (n_run < emit_cnt) begin
						n_err     = ERR_CAPACITY;
						res_err   = ERR_CAPACITY;
						res_valid = 1'b1;
					end
				end else begin
					n_run = ({{(SIZE_W-COUNT_W){1'b0}}, emit_cnt} < cap_q)
						? emit_cnt : cap_q[COUNT_W-1:0];
					n_cap = cap_q - {{(SIZE_W-COUNT_W){1'b0}}, n_run};
				end
				res_value = emit_val;
				res_count = n_run;
				if (n_run != '0) begin
					res_valid = 1'b1;
				end
			end

			if (chk_after && n_err == ERR_NONE && (n_line == '0 || n_line[LINE_W-1])) begin
				do_end = 1'b1;
			end

			// close the line: skip a pad word, else finish or await the next header
			if (do_end) begin
				n_hidx = 2'd0;
				if (n_pad) begin
					n_phase = PH_PAD;
				end else if (n_data == '0 || n_data[LINE_W-1]) begin
					n_phase   = PH_DONE;
					res_done  = 1'b1;
					res_valid = 1'b1;
				end else begin
					n_phase = PH_HDR;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q   <= 1'b0;
			transp_q <= '0;
			phase_q  <= PH_HDR;
			hidx_q   <= 2'd0;
			line_q   <= '0;
			data_q   <= '0;
			cap_q    <= '0;
			held_q   <= '0;
			low_q    <= '0;
			pad_q    <= 1'b0;
			err_q    <= ERR_NONE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_WIDE_PIXELS: wide_q <= cfg_data[0];
				CFG_TRANSPARENT: transp_q <= cfg_data[PIX_W-1:0];
				CFG_DATA_SIZE: begin
					data_q  <= {{(LINE_W-SIZE_W){1'b0}}, cfg_data};
					phase_q <= PH_HDR;
					hidx_q  <= 2'd0;
					line_q  <= '0;
					held_q  <= '0;
					low_q   <= '0;
					pad_q   <= 1'b0;
					err_q   <= ERR_NONE;
				end
				CFG_CAPACITY: cap_q <= cfg_data;
				default: begin
				end
			endcase
		end else if (take) begin
			phase_q <= n_phase;
			hidx_q  <= n_hidx;
			line_q  <= n_line;
			data_q  <= n_data;
			cap_q   <= n_cap;
			held_q  <= n_held;
			low_q   <= n_low;
			pad_q   <= n_pad;
			err_q   <= n_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (runs.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload until a new run replaces it
	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			out_value_q <= res_value;
			out_count_q <= res_count;
			out_done_q  <= res_done;
			out_err_q   <= res_err;
		end
	end

	assign runs.valid      = out_valid_q;
	assign runs.run_value  = out_value_q;
	assign runs.run_count  = out_count_q;
	assign runs.image_done = out_done_q;
	assign runs.error_code = out_err_q;

	a_done_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> hidx_q == 2'd0)
		else $error("header byte index left set after image end");

	a_pad_pending: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAD |-> pad_q)
		else $error("pad phase entered without a pending pad word");

	a_error_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(take && err_q != ERR_NONE && !cfg_wr_en) |=> $stable(cap_q) && $stable(phase_q))
		else $error("decoder state moved while an error was latched");

endmodule
`default_nettype wire
